### src/min_incident_edge_table_assert.svh
// Assertion macros for the minimum incident edge table.
`ifndef MIN_INCIDENT_EDGE_TABLE_ASSERT_SVH
`define MIN_INCIDENT_EDGE_TABLE_ASSERT_SVH

// Same-cycle implication, sampled on clk, off while rst is high.
`define MIET_ASSERT_NOW(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk, off while rst is high.
`define MIET_ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

### src/miet_pkg.sv
// Shared types and constants of the minimum incident edge table.
`timescale 1ns / 1ps

package miet_pkg;

  localparam int VERTEX_BITS = 6;
  localparam int VERTEX_LIMIT = 1 << VERTEX_BITS;
  localparam int COUNT_BITS = 7;
  localparam logic [COUNT_BITS-1:0] COUNT_RESET = 7'd64;

  typedef enum logic [1:0] {
    OP_ADD   = 2'd0,
    OP_QUERY = 2'd1,
    OP_CLEAR = 2'd2,
    OP_NOP   = 2'd3
  } op_t;

  // Command broadcast to every table entry in one cycle.
  typedef struct packed {
    logic                   add;
    logic                   clear;
    logic                   query;
    logic [VERTEX_BITS-1:0] vertex_a;
    logic [VERTEX_BITS-1:0] vertex_b;
    logic [VERTEX_BITS-1:0] query_vertex;
  } cell_cmd_t;

endpackage

### src/miet_cell.sv
// One table entry: keeps the cheapest edge offered to its vertex.
`timescale 1ns / 1ps

module miet_cell #(
  parameter int INDEX = 0,
  parameter int WEIGHT_BITS = 32,
  parameter int EDGE_INDEX_BITS = 16
) (
  input  logic                                clk,
  input  logic                                rst,
  input  miet_pkg::cell_cmd_t                 cmd,
  input  logic [WEIGHT_BITS-1:0]              edge_weight,
  input  logic [EDGE_INDEX_BITS-1:0]          edge_number,
  output logic                                entry_valid,
  output logic                                rd_found,
  output logic [miet_pkg::VERTEX_BITS-1:0]    rd_endpoint,
  output logic [WEIGHT_BITS-1:0]              rd_weight,
  output logic [EDGE_INDEX_BITS-1:0]          rd_edge_number
);

  localparam logic [miet_pkg::VERTEX_BITS-1:0] MY_VERTEX = miet_pkg::VERTEX_BITS'(INDEX);

  logic [miet_pkg::VERTEX_BITS-1:0] entry_endpoint;
  logic [WEIGHT_BITS-1:0]           entry_weight;
  logic [EDGE_INDEX_BITS-1:0]       entry_edge_number;

  logic                             hit_a;
  logic                             hit_b;
  logic                             take;
  logic [miet_pkg::VERTEX_BITS-1:0] far_end;
  logic                             sel;

  // A self loop hits both sides; far end is then the vertex itself.
  assign hit_a   = cmd.add && (cmd.vertex_a == MY_VERTEX);
  assign hit_b   = cmd.add && (cmd.vertex_b == MY_VERTEX);
  assign far_end = hit_a ? cmd.vertex_b : cmd.vertex_a;
  // Strict compare keeps the first of equal weights.
  assign take    = (hit_a || hit_b) && (!entry_valid || (edge_weight < entry_weight));

  always_ff @(posedge clk) begin
    if (rst) begin
      entry_valid <= 1'b0;
    end else if (cmd.clear) begin
      entry_valid <= 1'b0;
    end else if (take) begin
      entry_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      entry_endpoint    <= far_end;
      entry_weight      <= edge_weight;
      entry_edge_number <= edge_number;
    end
  end

  // Drive zeros unless this entry is the one queried and holds an edge.
  assign sel            = cmd.query && (cmd.query_vertex == MY_VERTEX) && entry_valid;
  assign rd_found       = sel;
  assign rd_endpoint    = sel ? entry_endpoint : '0;
  assign rd_weight      = sel ? entry_weight : '0;
  assign rd_edge_number = sel ? entry_edge_number : '0;

endmodule

### src/miet_skid.sv
// Result register with one skid slot, parting the table from the receiver.
`timescale 1ns / 1ps

module miet_skid #(
  parameter int DATA_BITS = 8
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  input  logic [DATA_BITS-1:0] in_data,
  output logic                 in_stall,
  output logic                 out_valid,
  output logic [DATA_BITS-1:0] out_data,
  input  logic                 out_stall
);

  logic                 head_valid;
  logic                 head_valid_next;
  logic [DATA_BITS-1:0] head_data;
  logic [DATA_BITS-1:0] head_data_next;
  logic                 skid_valid;
  logic                 skid_valid_next;
  logic [DATA_BITS-1:0] skid_data;
  logic [DATA_BITS-1:0] skid_data_next;
  logic                 take;
  logic                 head_free;

  assign in_stall  = skid_valid;
  assign take      = in_valid && !skid_valid;
  assign head_free = !head_valid || !out_stall;

  always_comb begin
    head_valid_next = head_valid;
    head_data_next  = head_data;
    skid_valid_next = skid_valid;
    skid_data_next  = skid_data;
    if (head_free) begin
      if (skid_valid) begin
        head_valid_next = 1'b1;
        head_data_next  = skid_data;
        skid_valid_next = 1'b0;
      end else begin
        head_valid_next = take;
        head_data_next  = in_data;
      end
    end else if (take) begin
      skid_valid_next = 1'b1;
      skid_data_next  = in_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head_valid <= 1'b0;
      skid_valid <= 1'b0;
    end else begin
      head_valid <= head_valid_next;
      skid_valid <= skid_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    head_data <= head_data_next;
    skid_data <= skid_data_next;
  end

  assign out_valid = head_valid;
  assign out_data  = head_data;

endmodule

### src/min_incident_edge_table.sv
// Top level of the minimum incident edge table (per-vertex cheapest edge).
//
// Usage:
// - Input channel (in_valid / in_stall) carries one command per transaction:
//   add edge, query a vertex, or clear the table. Opcode 3 does nothing.
// - Output channel (out_valid / out_stall) returns exactly one result
//   transaction per input transaction, in order.
// - cfg_we / cfg_data write vertex_count; write it only while idle.
// - Each result is registered before the output. Throughput: one
//   transaction per cycle while in_stall is low, set by the entry cells,
//   each of which does its compare and update in the accept cycle.
// - Every entry is its own cell, so both endpoints of an edge update in the
//   same cycle; a query reads the cells through an OR tree.
// - Reset empties the table at once (no clearing pass) and sets
//   vertex_count to 64.
// - When the receiver stalls, one more result is held in a skid slot; then
//   in_stall rises until the output drains.
`timescale 1ns / 1ps
`include "min_incident_edge_table_assert.svh"

module min_incident_edge_table #(
  parameter int MAX_VERTICES = 64,
  parameter int WEIGHT_BITS = 32,
  parameter int EDGE_INDEX_BITS = 16
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_we,
  input  logic [miet_pkg::COUNT_BITS-1:0]     cfg_data,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic [1:0]                          opcode,
  input  logic [miet_pkg::VERTEX_BITS-1:0]    vertex_a,
  input  logic [miet_pkg::VERTEX_BITS-1:0]    vertex_b,
  input  logic [WEIGHT_BITS-1:0]              edge_weight,
  input  logic [EDGE_INDEX_BITS-1:0]          edge_number,
  input  logic [miet_pkg::VERTEX_BITS-1:0]    query_vertex,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic                                found,
  output logic [miet_pkg::VERTEX_BITS-1:0]    far_endpoint,
  output logic [WEIGHT_BITS-1:0]              best_weight,
  output logic [EDGE_INDEX_BITS-1:0]          best_edge_number,
  output logic                                range_error
);

  // Only vertices reachable by the 6-bit fields get a cell.
  localparam int DEPTH = (MAX_VERTICES < miet_pkg::VERTEX_LIMIT) ?
                         MAX_VERTICES : miet_pkg::VERTEX_LIMIT;
  localparam int RES_BITS = 1 + miet_pkg::VERTEX_BITS + WEIGHT_BITS + EDGE_INDEX_BITS + 1;

  logic [miet_pkg::COUNT_BITS-1:0] vertex_count;

  logic                in_fire;
  miet_pkg::op_t       op;
  logic                a_ok;
  logic                b_ok;
  logic                q_ok;
  miet_pkg::cell_cmd_t cmd;

  logic [DEPTH-1:0]                 cell_valid;
  logic [DEPTH-1:0]                 cell_found;
  logic [miet_pkg::VERTEX_BITS-1:0] cell_endpoint    [DEPTH];
  logic [WEIGHT_BITS-1:0]           cell_weight      [DEPTH];
  logic [EDGE_INDEX_BITS-1:0]       cell_edge_number [DEPTH];

  logic [miet_pkg::VERTEX_BITS-1:0] rd_endpoint;
  logic [WEIGHT_BITS-1:0]           rd_weight;
  logic [EDGE_INDEX_BITS-1:0]       rd_edge_number;
  logic                             res_range_error;
  logic [RES_BITS-1:0]              res_data;
  logic [RES_BITS-1:0]              out_data;

  // Hold the vertex bound; the user writes it only while idle, unenforced here.
  always_ff @(posedge clk) begin
    if (rst) begin
      vertex_count <= miet_pkg::COUNT_RESET;
    end else if (cfg_we) begin
      vertex_count <= cfg_data;
    end
  end

  function automatic logic vertex_ok(input logic [miet_pkg::VERTEX_BITS-1:0] v,
                                     input logic [miet_pkg::COUNT_BITS-1:0] count);
    logic below_count;
    logic below_max;
    below_count = {1'b0, v} < count;
    below_max   = 32'(v) < MAX_VERTICES;
    return below_count && below_max;
  endfunction

  assign in_fire = in_valid && !in_stall;
  assign op      = miet_pkg::op_t'(opcode);
  assign a_ok    = vertex_ok(vertex_a, vertex_count);
  assign b_ok    = vertex_ok(vertex_b, vertex_count);
  assign q_ok    = vertex_ok(query_vertex, vertex_count);

  // Decode the transaction into one command for all cells.
  always_comb begin
    cmd              = '0;
    cmd.vertex_a     = vertex_a;
    cmd.vertex_b     = vertex_b;
    cmd.query_vertex = query_vertex;
    res_range_error  = 1'b0;
    case (op)
      miet_pkg::OP_ADD: begin
        cmd.add         = in_fire && a_ok && b_ok;
        res_range_error = !(a_ok && b_ok);
      end
      miet_pkg::OP_QUERY: begin
        cmd.query       = q_ok;
        res_range_error = !q_ok;
      end
      miet_pkg::OP_CLEAR: begin
        cmd.clear = in_fire;
      end
      default: begin
        // No operation: all-zero result.
      end
    endcase
  end

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    miet_cell #(
      .INDEX          (i),
      .WEIGHT_BITS    (WEIGHT_BITS),
      .EDGE_INDEX_BITS(EDGE_INDEX_BITS)
    ) u_cell (
      .clk           (clk),
      .rst           (rst),
      .cmd           (cmd),
      .edge_weight   (edge_weight),
      .edge_number   (edge_number),
      .entry_valid   (cell_valid[i]),
      .rd_found      (cell_found[i]),
      .rd_endpoint   (cell_endpoint[i]),
      .rd_weight     (cell_weight[i]),
      .rd_edge_number(cell_edge_number[i])
    );
  end

  // At most one cell drives a nonzero read, so OR the cells together.
  always_comb begin
    rd_endpoint    = '0;
    rd_weight      = '0;
    rd_edge_number = '0;
    for (int i = 0; i < DEPTH; i++) begin
      rd_endpoint    = rd_endpoint | cell_endpoint[i];
      rd_weight      = rd_weight | cell_weight[i];
      rd_edge_number = rd_edge_number | cell_edge_number[i];
    end
  end

  assign res_data = {|cell_found, rd_endpoint, rd_weight, rd_edge_number, res_range_error};

  miet_skid #(
    .DATA_BITS(RES_BITS)
  ) u_skid (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_data  (res_data),
    .in_stall (in_stall),
    .out_valid(out_valid),
    .out_data (out_data),
    .out_stall(out_stall)
  );

  assign {found, far_endpoint, best_weight, best_edge_number, range_error} = out_data;

  `MIET_ASSERT_NOW(a_skid_behind_head, in_stall, out_valid,
                   "skid slot full while result register empty")
  `MIET_ASSERT_NOW(a_found_in_range, out_valid, !(found && range_error),
                   "result both found and out of range")
  `MIET_ASSERT_NEXT(a_clear_empties, in_fire && (op == miet_pkg::OP_CLEAR), cell_valid == '0,
                    "table not empty after clear")

endmodule
